[rtl/core/svpwm_pkg.sv]
package svpwm_pkg;

    // sqrt(3)/2 in Q16.
    localparam logic [15:0] SQRT3_HALF_Q16 = 16'd56756;

    // Sector bounds of the angle, a full turn over 16 bits.
    localparam logic [15:0] ANG60  = 16'd10923;
    localparam logic [15:0] ANG120 = 16'd21845;
    localparam logic [15:0] ANG180 = 16'd32768;
    localparam logic [15:0] ANG240 = 16'd43691;
    localparam logic [15:0] ANG300 = 16'd54613;

    // Sector numbers.
    localparam logic [2:0] SECTOR_1 = 3'd1;
    localparam logic [2:0] SECTOR_2 = 3'd2;
    localparam logic [2:0] SECTOR_3 = 3'd3;
    localparam logic [2:0] SECTOR_4 = 3'd4;
    localparam logic [2:0] SECTOR_5 = 3'd5;
    localparam logic [2:0] SECTOR_6 = 3'd6;

    // Configuration register indexes.
    localparam logic [1:0] REG_PWM_PERIOD   = 2'd0;
    localparam logic [1:0] REG_MIN_DUTY     = 2'd1;
    localparam logic [1:0] REG_MAX_DUTY     = 2'd2;
    localparam logic [1:0] REG_RELOAD_VALUE = 2'd3;

    // Configuration reset values.
    localparam logic [15:0] PWM_PERIOD_RST   = 16'd4096;
    localparam logic [15:0] MIN_DUTY_RST     = 16'd0;
    localparam logic [15:0] MAX_DUTY_RST     = 16'd4096;
    localparam logic [15:0] RELOAD_VALUE_RST = 16'd4096;

    // Default depth of the queue between front and back.
    localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

    typedef struct packed {
        logic [15:0] pwm_period;
        logic [15:0] min_duty;
        logic [15:0] max_duty;
        logic [15:0] reload_value;
    } cfg_t;

    // One classified item handed from the front to the back.
    typedef struct packed {
        logic [2:0]         sector;
        logic [15:0]        m_scale;
        logic [14:0]        t_a;
        logic [14:0]        t_b;
        logic signed [15:0] u_alpha;
        logic signed [15:0] u_beta;
    } vec_item_t;

endpackage

[rtl/core/svpwm_front.sv]
module svpwm_front import svpwm_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [15:0]        pwm_period,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [15:0]        theta,
    input  logic signed [15:0] sin_q15,
    input  logic signed [15:0] cos_q15,
    input  logic [15:0]        us,
    output logic               push_valid,
    output vec_item_t          push_item,
    input  logic               queue_full
);

    logic               fe;
    logic [2:0]         sector_next;
    logic signed [32:0] hi_prod;
    logic signed [32:0] ua_prod;
    logic signed [32:0] ub_prod;
    logic [31:0]        m_prod;

    logic               f1_valid_reg, f1_valid_next;
    logic [2:0]         f1_sector_reg;
    logic signed [15:0] f1_sin_reg;
    logic [15:0]        f1_hi_reg;
    logic [15:0]        f1_m_reg;
    logic signed [15:0] f1_ua_reg;
    logic signed [15:0] f1_ub_reg;

    logic signed [15:0] s_half;
    logic [15:0]        y_val, z_val, a_val, b_val;
    vec_item_t          f2_item_next;
    logic               f2_valid_reg, f2_valid_next;
    vec_item_t          f2_item_reg;

    // The whole front advances unless its last stage holds an item the queue cannot take.
    assign fe         = !f2_valid_reg || !queue_full;
    assign in_ready   = fe;
    assign push_valid = f2_valid_reg && !queue_full;
    assign push_item  = f2_item_reg;

    // Stage one: sector search and the products of the input transfer.
    always_comb begin
        if (theta < ANG60) begin
            sector_next = SECTOR_1;
        end else if (theta < ANG120) begin
            sector_next = SECTOR_2;
        end else if (theta < ANG180) begin
            sector_next = SECTOR_3;
        end else if (theta < ANG240) begin
            sector_next = SECTOR_4;
        end else if (theta < ANG300) begin
            sector_next = SECTOR_5;
        end else begin
            sector_next = SECTOR_6;
        end
        hi_prod = $signed({1'b0, SQRT3_HALF_Q16}) * cos_q15;
        ua_prod = $signed({1'b0, us}) * cos_q15;
        ub_prod = $signed({1'b0, us}) * sin_q15;
        m_prod  = us * pwm_period;
    end

    // Stage two: X, Y and Z, then the sector's pair of vector times.
    always_comb begin
        s_half = f1_sin_reg >>> 1;
        y_val  = 16'(s_half) + f1_hi_reg;
        z_val  = 16'(s_half) - f1_hi_reg;
        unique case (f1_sector_reg)
            SECTOR_1: begin
                a_val = 16'(-z_val);
                b_val = 16'(f1_sin_reg);
            end
            SECTOR_2: begin
                a_val = z_val;
                b_val = y_val;
            end
            SECTOR_3: begin
                a_val = 16'(f1_sin_reg);
                b_val = 16'(-y_val);
            end
            SECTOR_4: begin
                a_val = 16'(-f1_sin_reg);
                b_val = z_val;
            end
            SECTOR_5: begin
                a_val = 16'(-y_val);
                b_val = 16'(-z_val);
            end
            default: begin
                a_val = y_val;
                b_val = 16'(-f1_sin_reg);
            end
        endcase
        f2_item_next.sector  = f1_sector_reg;
        f2_item_next.m_scale = f1_m_reg;
        // Negative times are clamped to zero.
        f2_item_next.t_a     = a_val[15] ? 15'd0 : a_val[14:0];
        f2_item_next.t_b     = b_val[15] ? 15'd0 : b_val[14:0];
        f2_item_next.u_alpha = f1_ua_reg;
        f2_item_next.u_beta  = f1_ub_reg;
    end

    // Valid bits of both stages.
    always_comb begin
        f1_valid_next = f1_valid_reg;
        f2_valid_next = f2_valid_reg;
        if (fe) begin
            f1_valid_next = in_valid;
            f2_valid_next = f1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end else begin
            f1_valid_reg <= f1_valid_next;
            f2_valid_reg <= f2_valid_next;
        end
    end

    // Payload registers move with the stage enable.
    always_ff @(posedge aclk) begin
        if (fe) begin
            f1_sector_reg <= sector_next;
            f1_sin_reg    <= sin_q15;
            f1_hi_reg     <= hi_prod[31:16];
            f1_m_reg      <= m_prod[31:16];
            f1_ua_reg     <= ua_prod[31:16];
            f1_ub_reg     <= ub_prod[31:16];
            f2_item_reg   <= f2_item_next;
        end
    end

endmodule

[rtl/core/svpwm_queue.sv]
module svpwm_queue import svpwm_pkg::*; #(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push_valid,
    input  vec_item_t push_item,
    output logic      full,
    output logic      pop_valid,
    input  logic      pop_ready,
    output vec_item_t pop_item
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    vec_item_t        slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == FULL_CNT);
    assign pop_valid = (count_reg != '0);
    assign pop_item  = slot_reg[rd_ptr_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop_valid && pop_ready;

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Slot storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[rtl/core/svpwm_back.sv]
module svpwm_back import svpwm_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  vec_item_t          pop_item,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [15:0]        duty_u,
    output logic [15:0]        duty_v,
    output logic [15:0]        duty_w,
    output logic [2:0]         sector,
    output logic signed [15:0] u_alpha,
    output logic signed [15:0] u_beta
);

    // Clamp one phase time to the duty window and subtract it from the reload.
    function automatic logic [15:0] clamp_sub(input logic [15:0] t, input cfg_t c);
        logic [15:0] v;
        v = t;
        if (v < c.min_duty) begin
            v = c.min_duty;
        end
        if (v > c.max_duty) begin
            v = c.max_duty;
        end
        return c.reload_value - v;
    endfunction

    logic               be;
    logic [30:0]        ta_prod, tb_prod;
    logic [17:0]        diff;
    logic [15:0]        tc_val, tbo_val, tao_val;
    logic [15:0]        pu, pv, pw;

    logic               b1_valid_reg, b1_valid_next;
    logic [2:0]         b1_sector_reg;
    logic [15:0]        b1_ta_reg, b1_tb_reg;
    logic signed [15:0] b1_ua_reg, b1_ub_reg;

    logic               b2_valid_reg, b2_valid_next;
    logic [2:0]         b2_sector_reg;
    logic [15:0]        b2_tc_reg, b2_tbo_reg, b2_tao_reg;
    logic signed [15:0] b2_ua_reg, b2_ub_reg;

    logic               out_valid_reg, out_valid_next;
    logic [15:0]        duty_u_reg, duty_v_reg, duty_w_reg;
    logic [2:0]         sector_reg;
    logic signed [15:0] u_alpha_reg, u_beta_reg;

    // The back advances whenever the output register is empty or being drained.
    assign be        = !out_valid_reg || out_ready;
    assign pop_ready = be;
    assign out_valid = out_valid_reg;
    assign duty_u    = duty_u_reg;
    assign duty_v    = duty_v_reg;
    assign duty_w    = duty_w_reg;
    assign sector    = sector_reg;
    assign u_alpha   = u_alpha_reg;
    assign u_beta    = u_beta_reg;

    // Stage one: scale both vector times by the period-weighted magnitude.
    always_comb begin
        ta_prod = pop_item.m_scale * pop_item.t_a;
        tb_prod = pop_item.m_scale * pop_item.t_b;
    end

    // Stage two: zero-vector time and the two cumulative compare times.
    always_comb begin
        diff    = {2'b00, cfg.pwm_period} - {2'b00, b1_ta_reg} - {2'b00, b1_tb_reg};
        tc_val  = diff[17:2];
        tbo_val = {1'b0, b1_tb_reg[15:1]} + tc_val;
        tao_val = {1'b0, b1_ta_reg[15:1]} + tbo_val;
    end

    // Stage three: route the times to the phases by sector.
    always_comb begin
        unique case (b2_sector_reg)
            SECTOR_1: begin
                pu = b2_tao_reg; pv = b2_tbo_reg; pw = b2_tc_reg;
            end
            SECTOR_2: begin
                pu = b2_tbo_reg; pv = b2_tao_reg; pw = b2_tc_reg;
            end
            SECTOR_3: begin
                pu = b2_tc_reg;  pv = b2_tao_reg; pw = b2_tbo_reg;
            end
            SECTOR_4: begin
                pu = b2_tc_reg;  pv = b2_tbo_reg; pw = b2_tao_reg;
            end
            SECTOR_5: begin
                pu = b2_tbo_reg; pv = b2_tc_reg;  pw = b2_tao_reg;
            end
            default: begin
                pu = b2_tao_reg; pv = b2_tc_reg;  pw = b2_tbo_reg;
            end
        endcase
    end

    // Valid bits of the three stages.
    always_comb begin
        b1_valid_next  = b1_valid_reg;
        b2_valid_next  = b2_valid_reg;
        out_valid_next = out_valid_reg;
        if (be) begin
            b1_valid_next  = pop_valid;
            b2_valid_next  = b1_valid_reg;
            out_valid_next = b2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            b1_valid_reg  <= b1_valid_next;
            b2_valid_reg  <= b2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers move with the stage enable.
    always_ff @(posedge aclk) begin
        if (be) begin
            b1_sector_reg <= pop_item.sector;
            b1_ta_reg     <= {ta_prod[30:16], 1'b0};
            b1_tb_reg     <= {tb_prod[30:16], 1'b0};
            b1_ua_reg     <= pop_item.u_alpha;
            b1_ub_reg     <= pop_item.u_beta;

            b2_sector_reg <= b1_sector_reg;
            b2_tc_reg     <= tc_val;
            b2_tbo_reg    <= tbo_val;
            b2_tao_reg    <= tao_val;
            b2_ua_reg     <= b1_ua_reg;
            b2_ub_reg     <= b1_ub_reg;

            duty_u_reg    <= clamp_sub(pu, cfg);
            duty_v_reg    <= clamp_sub(pv, cfg);
            duty_w_reg    <= clamp_sub(pw, cfg);
            sector_reg    <= b2_sector_reg;
            u_alpha_reg   <= b2_ua_reg;
            u_beta_reg    <= b2_ub_reg;
        end
    end

endmodule

[rtl/core/svpwm_duty_calculator_top.sv]
// Channel   Direction  Handshake                      Payload
// s_        in         s_tvalid / s_tready            s_tdata: theta, sin_q15, cos_q15, us
// m_        out        m_tvalid / m_tready            m_tdata: duty_u/v/w, sector, u_alpha, u_beta
// cfg_      in         cfg_wr_en (no handshake back)  cfg_addr, cfg_wdata
//
// Sustained rate is one item per clock while the output is not stalled; an item
// passes two front stages (sector and products, then vector times), the queue slots
// and three back stages (scaling, compare times, clamp) from input to result.
// Reset is synchronous and active low; it empties the pipeline and queue and loads
// the register defaults, with no clearing pass. A stalled output holds the back;
// the queue keeps the front taking items until it fills.
module svpwm_duty_calculator_top import svpwm_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // theta[15:0], sin_q15[31:16], cos_q15[47:32], us[63:48]
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // duty_u[15:0], duty_v[31:16], duty_w[47:32], sector[50:48],
    // u_alpha[66:51], u_beta[82:67], zero fill[87:83]
    output logic [87:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    cfg_t               cfg_reg, cfg_next;
    logic               push_valid, queue_full;
    vec_item_t          push_item, pop_item;
    logic               pop_valid, pop_ready;
    logic [15:0]        duty_u, duty_v, duty_w;
    logic [2:0]         sector;
    logic signed [15:0] u_alpha, u_beta;

    // Configuration register writes.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_PWM_PERIOD:   cfg_next.pwm_period   = cfg_wdata;
                REG_MIN_DUTY:     cfg_next.min_duty     = cfg_wdata;
                REG_MAX_DUTY:     cfg_next.max_duty     = cfg_wdata;
                REG_RELOAD_VALUE: cfg_next.reload_value = cfg_wdata;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pwm_period   <= PWM_PERIOD_RST;
            cfg_reg.min_duty     <= MIN_DUTY_RST;
            cfg_reg.max_duty     <= MAX_DUTY_RST;
            cfg_reg.reload_value <= RELOAD_VALUE_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    svpwm_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pwm_period (cfg_reg.pwm_period),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .theta      (s_tdata[15:0]),
        .sin_q15    ($signed(s_tdata[31:16])),
        .cos_q15    ($signed(s_tdata[47:32])),
        .us         (s_tdata[63:48]),
        .push_valid (push_valid),
        .push_item  (push_item),
        .queue_full (queue_full)
    );

    svpwm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_item  (push_item),
        .full       (queue_full),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    svpwm_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .duty_u    (duty_u),
        .duty_v    (duty_v),
        .duty_w    (duty_w),
        .sector    (sector),
        .u_alpha   (u_alpha),
        .u_beta    (u_beta)
    );

    // Result packing, duty_u in the lowest bits.
    assign m_tdata = {5'b00000, u_beta, u_alpha, sector, duty_w, duty_v, duty_u};

endmodule

[tb/svpwm_duty_calculator_top_tb.sv]
`timescale 1ns / 1ps

module svpwm_duty_calculator_top_tb import svpwm_pkg::*; ();

    localparam int unsigned HOLD_CYCLES  = 120;
    localparam int unsigned DRAIN_CYCLES = 12;
    localparam int unsigned MAX_REPORTS  = 50;
    localparam longint      TIMEOUT_NS   = 5_000_000;

    // Input transfer, theta in the lowest bits as on s_tdata.
    typedef struct packed {
        logic [15:0]        us;
        logic signed [15:0] cos_q15;
        logic signed [15:0] sin_q15;
        logic [15:0]        theta;
    } vec_in_t;

    // Result transfer, duty_u in the lowest bits as on m_tdata.
    typedef struct packed {
        logic [4:0]         fill;
        logic signed [15:0] u_beta;
        logic signed [15:0] u_alpha;
        logic [2:0]         sector;
        logic [15:0]        duty_w;
        logic [15:0]        duty_v;
        logic [15:0]        duty_u;
    } duty_out_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    // theta[15:0], sin_q15[31:16], cos_q15[47:32], us[63:48]
    logic [63:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    // duty_u[15:0], duty_v[31:16], duty_w[47:32], sector[50:48],
    // u_alpha[66:51], u_beta[82:67], zero fill[87:83]
    logic [87:0] m_tdata;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_addr  = REG_PWM_PERIOD;
    logic [15:0] cfg_wdata = '0;

    // Register copy used by the duty predictor.
    cfg_t cfg_model = '{PWM_PERIOD_RST, MIN_DUTY_RST, MAX_DUTY_RST, RELOAD_VALUE_RST};

    vec_in_t     vector_queue[$];
    duty_out_t   duty_queue[$];
    int unsigned send_gap      = 0;
    int unsigned send_run      = 0;
    int unsigned recv_wait     = 0;
    int unsigned recv_run      = 0;
    bit          send_flat     = 1'b0;
    bit          hold_req      = 1'b0;
    int unsigned mismatch_count = 0;
    int unsigned input_count   = 0;
    int unsigned result_count  = 0;
    int unsigned setting_count = 0;

    svpwm_duty_calculator_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Reduce to 16-bit two's complement and sign extend again.
    function automatic longint wrap16(longint val);
        logic signed [15:0] t;
        t = val[15:0];
        return longint'(t);
    endfunction

    // Vector time scaled by the magnitude product; negative times count as zero.
    function automatic longint scale_time(longint mag, longint t);
        if (t < 0) begin
            t = 0;
        end
        return (((mag * t) >>> 16) << 1) & 64'hFFFF;
    endfunction

    // Clamp one phase time to the duty window and take it from the reload.
    function automatic logic [15:0] clamp_phase(logic [15:0] t);
        if (t < cfg_model.min_duty) begin
            t = cfg_model.min_duty;
        end
        if (t > cfg_model.max_duty) begin
            t = cfg_model.max_duty;
        end
        return cfg_model.reload_value - t;
    endfunction

    // Expected compare values, sector and alpha/beta voltages for one vector.
    function automatic duty_out_t compute_duties(vec_in_t v);
        duty_out_t   r;
        logic [2:0]  sec;
        longint      s, c, hi, x, y, z, a, b, mag, ta, tb, diff, tc, tbo, tao;
        logic [15:0] ph_u, ph_v, ph_w;
        longint      prod;
        s = longint'(v.sin_q15);
        c = longint'(v.cos_q15);

        if (v.theta < ANG60) begin
            sec = SECTOR_1;
        end else if (v.theta < ANG120) begin
            sec = SECTOR_2;
        end else if (v.theta < ANG180) begin
            sec = SECTOR_3;
        end else if (v.theta < ANG240) begin
            sec = SECTOR_4;
        end else if (v.theta < ANG300) begin
            sec = SECTOR_5;
        end else begin
            sec = SECTOR_6;
        end

        x  = s;
        hi = (longint'(SQRT3_HALF_Q16) * c) >>> 16;
        y  = wrap16((s >>> 1) + hi);
        z  = wrap16((s >>> 1) - hi);

        // Pair of active vector times for the sector.
        case (sec)
            SECTOR_1: begin a = wrap16(-z); b = x;          end
            SECTOR_2: begin a = z;          b = y;          end
            SECTOR_3: begin a = x;          b = wrap16(-y); end
            SECTOR_4: begin a = wrap16(-x); b = z;          end
            SECTOR_5: begin a = wrap16(-y); b = wrap16(-z); end
            default:  begin a = y;          b = wrap16(-x); end
        endcase

        mag  = (longint'(v.us) * longint'(cfg_model.pwm_period)) >>> 16;
        ta   = scale_time(mag, a);
        tb   = scale_time(mag, b);
        diff = longint'(cfg_model.pwm_period) - ta - tb;
        tc   = (diff >>> 2) & 64'hFFFF;
        tbo  = ((tb >>> 1) + tc) & 64'hFFFF;
        tao  = ((ta >>> 1) + tbo) & 64'hFFFF;

        // Map the three times onto the phases.
        case (sec)
            SECTOR_1: begin ph_u = tao[15:0]; ph_v = tbo[15:0]; ph_w = tc[15:0];  end
            SECTOR_2: begin ph_u = tbo[15:0]; ph_v = tao[15:0]; ph_w = tc[15:0];  end
            SECTOR_3: begin ph_u = tc[15:0];  ph_v = tao[15:0]; ph_w = tbo[15:0]; end
            SECTOR_4: begin ph_u = tc[15:0];  ph_v = tbo[15:0]; ph_w = tao[15:0]; end
            SECTOR_5: begin ph_u = tbo[15:0]; ph_v = tc[15:0];  ph_w = tao[15:0]; end
            default:  begin ph_u = tao[15:0]; ph_v = tc[15:0];  ph_w = tbo[15:0]; end
        endcase

        r.fill    = '0;
        r.duty_u  = clamp_phase(ph_u);
        r.duty_v  = clamp_phase(ph_v);
        r.duty_w  = clamp_phase(ph_w);
        r.sector  = sec;
        prod      = (longint'(v.us) * c) >>> 16;
        r.u_alpha = prod[15:0];
        prod      = (longint'(v.us) * s) >>> 16;
        r.u_beta  = prod[15:0];
        return r;
    endfunction

    // Idle cycles before the next item: mostly random, sometimes a run of none.
    function automatic int unsigned draw_idle(inout int unsigned run);
        if (run > 0) begin
            run--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            run = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            if (mismatch_count < MAX_REPORTS) begin
                $display("%0t ns: %s expected 0x%h, actual 0x%h", $time, name, want, got);
            end
            mismatch_count++;
        end
    endtask

    // Input driver: offers queued vectors and predicts each accepted transfer.
    always @(posedge aclk) begin : driver_proc
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                duty_queue.push_back(compute_duties(s_tdata));
                input_count++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    s_tvalid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (vector_queue.size() > 0) begin
                    s_tdata  <= vector_queue.pop_front();
                    s_tvalid <= 1'b1;
                    send_gap <= send_flat ? 0 : draw_idle(send_run);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks every result transfer and paces m_tready.
    always @(posedge aclk) begin : monitor_proc
        duty_out_t   got;
        duty_out_t   want;
        int unsigned wait_n;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            recv_wait <= 0;
        end else begin
            wait_n = recv_wait;
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                result_count++;
                if (duty_queue.size() == 0) begin
                    if (mismatch_count < MAX_REPORTS) begin
                        $display("%0t ns: unexpected result, expected none, actual 0x%h",
                                 $time, got);
                    end
                    mismatch_count++;
                end else begin
                    want = duty_queue.pop_front();
                    check_field("duty_u", want.duty_u, got.duty_u);
                    check_field("duty_v", want.duty_v, got.duty_v);
                    check_field("duty_w", want.duty_w, got.duty_w);
                    check_field("sector", 16'(want.sector), 16'(got.sector));
                    check_field("u_alpha", want.u_alpha, got.u_alpha);
                    check_field("u_beta", want.u_beta, got.u_beta);
                    check_field("zero fill", 16'(want.fill), 16'(got.fill));
                end
                wait_n = draw_idle(recv_run);
            end
            // A requested long stall overrides the normal pacing.
            if (hold_req) begin
                wait_n   = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (wait_n > 0) begin
                m_tready  <= 1'b0;
                recv_wait <= wait_n - 1;
            end else begin
                m_tready  <= 1'b1;
                recv_wait <= 0;
            end
        end
    end

    function automatic vec_in_t raw_vector(logic [15:0] theta, logic [15:0] s, logic [15:0] c,
                                           logic [15:0] us);
        vec_in_t v;
        v.theta   = theta;
        v.sin_q15 = s;
        v.cos_q15 = c;
        v.us      = us;
        return v;
    endfunction

    // Consistent angle, sine and cosine.
    function automatic vec_in_t unit_vector(logic [15:0] theta, logic [15:0] us);
        real ang;
        int  s, c;
        ang = 6.283185307179586 * real'(theta) / 65536.0;
        s   = $rtoi(32767.0 * $sin(ang));
        c   = $rtoi(32767.0 * $cos(ang));
        return raw_vector(theta, s[15:0], c[15:0], us);
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_PWM_PERIOD:   cfg_model.pwm_period   = val;
            REG_MIN_DUTY:     cfg_model.min_duty     = val;
            REG_MAX_DUTY:     cfg_model.max_duty     = val;
            REG_RELOAD_VALUE: cfg_model.reload_value = val;
            default: ;
        endcase
    endtask

    task automatic set_config(logic [15:0] period, logic [15:0] lo, logic [15:0] hi,
                              logic [15:0] reload);
        write_reg(REG_PWM_PERIOD, period);
        write_reg(REG_MIN_DUTY, lo);
        write_reg(REG_MAX_DUTY, hi);
        write_reg(REG_RELOAD_VALUE, reload);
        setting_count++;
    endtask

    // Wait until every queued vector has been transferred and checked.
    task automatic drain();
        do begin
            @(negedge aclk);
        end while (vector_queue.size() > 0 || s_tvalid || duty_queue.size() > 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Mostly realistic vectors; about one in five is raw noise on every bit.
    task automatic queue_random(int unsigned count);
        for (int unsigned i = 0; i < count; i++) begin
            if ($urandom_range(0, 4) == 0) begin
                vector_queue.push_back(vec_in_t'({$urandom, $urandom}));
            end else begin
                vector_queue.push_back(unit_vector(16'($urandom_range(0, 65535)),
                                                   16'($urandom_range(0, 65535))));
            end
        end
    endtask

    initial begin : sequence_proc
        logic [15:0] bounds[12];
        bounds = '{16'd0, 16'd10922, 16'd10923, 16'd21844, 16'd21845, 16'd32767,
                   16'd32768, 16'd43690, 16'd43691, 16'd54612, 16'd54613, 16'd65535};
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        setting_count = 1;

        // Directed: sector edges at full magnitude, then out-of-range sine and cosine and zero magnitude.
        foreach (bounds[i]) begin
            vector_queue.push_back(unit_vector(bounds[i], 16'hFFFF));
        end
        vector_queue.push_back(raw_vector(16'd0, 16'h8000, 16'h8000, 16'hFFFF));
        vector_queue.push_back(raw_vector(16'd32768, 16'h8000, 16'h7FFF, 16'hFFFF));
        vector_queue.push_back(raw_vector(16'd65535, 16'h7FFF, 16'h8000, 16'hFFFF));
        vector_queue.push_back(raw_vector(16'd20000, 16'h7FFF, 16'h7FFF, 16'hFFFF));
        vector_queue.push_back(raw_vector(16'd45000, 16'h8000, 16'h0000, 16'hFFFF));
        vector_queue.push_back(raw_vector(16'd50000, 16'h8000, 16'h8000, 16'hFFFF));
        vector_queue.push_back(raw_vector(16'd12345, 16'h0000, 16'h0000, 16'h0000));
        vector_queue.push_back(unit_vector(16'd5000, 16'h0000));
        queue_random(60);
        drain();

        // Widest window and full reload.
        set_config(16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF);
        queue_random(60);
        drain();

        // Everything at zero.
        set_config(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        queue_random(40);
        drain();

        // Lower clamp above the upper one.
        set_config(16'd3000, 16'd2000, 16'd1000, 16'hFFFF);
        queue_random(50);
        drain();

        // Zero reload so that every duty wraps.
        set_config(16'd20000, 16'd100, 16'd19000, 16'h0000);
        queue_random(50);
        drain();

        // Random settings.
        repeat (2) begin
            set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                       16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
            queue_random(50);
            drain();
        end

        // Long output stall with back-to-back input so the block backs up.
        set_config(PWM_PERIOD_RST, MIN_DUTY_RST, MAX_DUTY_RST, RELOAD_VALUE_RST);
        send_flat = 1'b1;
        hold_req  = 1'b1;
        queue_random(40);
        drain();
        send_flat = 1'b0;

        $display("Run covered %0d input and %0d result transfers over %0d register settings,",
                 input_count, result_count, setting_count);
        $display("including sector edges, saturated inputs and a long output stall.");
        if (mismatch_count == 0) begin
            $display("PASS svpwm_duty_calculator_top");
        end else begin
            $display("FAIL svpwm_duty_calculator_top");
        end
        $finish;
    end

    initial begin : watchdog_proc
        #(TIMEOUT_NS);
        $display("FAIL svpwm_duty_calculator_top");
        $finish;
    end

endmodule

[sim.f]
rtl/core/svpwm_pkg.sv
rtl/core/svpwm_front.sv
rtl/core/svpwm_queue.sv
rtl/core/svpwm_back.sv
rtl/core/svpwm_duty_calculator_top.sv
tb/svpwm_duty_calculator_top_tb.sv
